// ----- rtl/pwsfd_pkg.sv -----
`timescale 1ns / 1ps

package pwsfd_pkg;

    // Default sizes handed to the top level.
    localparam int DEF_FRAME_BITS = 36;
    localparam int DEF_WIDTH_BITS = 16;

    // Configuration register file geometry.
    localparam int REG_W     = 16;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 3;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SYNC_MIN = 3'd0,
        REG_SYNC_MAX = 3'd1,
        REG_ZERO_MIN = 3'd2,
        REG_ZERO_MAX = 3'd3,
        REG_ONE_MIN  = 3'd4,
        REG_ONE_MAX  = 3'd5,
        REG_MARK_MIN = 3'd6,
        REG_MARK_MAX = 3'd7
    } cfg_index_t;

    // Register values after reset.
    localparam logic [REG_W-1:0] RST_SYNC_MIN = 16'd7500;
    localparam logic [REG_W-1:0] RST_SYNC_MAX = 16'd10000;
    localparam logic [REG_W-1:0] RST_ZERO_MIN = 16'd1500;
    localparam logic [REG_W-1:0] RST_ZERO_MAX = 16'd2500;
    localparam logic [REG_W-1:0] RST_ONE_MIN  = 16'd3500;
    localparam logic [REG_W-1:0] RST_ONE_MAX  = 16'd4500;
    localparam logic [REG_W-1:0] RST_MARK_MIN = 16'd330;
    localparam logic [REG_W-1:0] RST_MARK_MAX = 16'd530;

    // Pulse width windows, all exclusive on both ends.
    typedef struct packed {
        logic [REG_W-1:0] sync_min;
        logic [REG_W-1:0] sync_max;
        logic [REG_W-1:0] zero_min;
        logic [REG_W-1:0] zero_max;
        logic [REG_W-1:0] one_min;
        logic [REG_W-1:0] one_max;
        logic [REG_W-1:0] mark_min;
        logic [REG_W-1:0] mark_max;
    } windows_t;

    // Decoded frame fields.
    localparam int SENSOR_ID_W  = 4;
    localparam int ROLLING_ID_W = 8;
    localparam int CHANNEL_W    = 3;
    localparam int CH_BITS_W    = 2;
    localparam int TEMP_W       = 12;

    // Frame layout, counted from the first bit received.
    localparam int POS_SENSOR_ID  = 0;
    localparam int POS_ROLLING_ID = 4;
    localparam int POS_BATTERY    = 12;
    localparam int POS_BUTTON     = 13;
    localparam int POS_CHANNEL    = 14;
    localparam int POS_TEMP       = 16;

    typedef struct packed {
        logic                     frame_done;
        logic [SENSOR_ID_W-1:0]   sensor_id;
        logic [ROLLING_ID_W-1:0]  rolling_id;
        logic                     battery_flag;
        logic                     button_flag;
        logic [CHANNEL_W-1:0]     channel;
        logic signed [TEMP_W-1:0] temperature;
    } result_t;

    // Result stream packing.
    localparam int OUT_FIELDS_W = TEMP_W + CHANNEL_W + 1 + 1 + ROLLING_ID_W + SENSOR_ID_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

endpackage

// ----- rtl/pwsfd_cfg_regs.sv -----
`timescale 1ns / 1ps

module pwsfd_cfg_regs
    import pwsfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    output windows_t             windows
);

    windows_t win_reg;
    windows_t win_next;

    // Write decode for the window registers.
    always_comb
    begin
        win_next = win_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_SYNC_MIN: win_next.sync_min = cfg_data;
                REG_SYNC_MAX: win_next.sync_max = cfg_data;
                REG_ZERO_MIN: win_next.zero_min = cfg_data;
                REG_ZERO_MAX: win_next.zero_max = cfg_data;
                REG_ONE_MIN:  win_next.one_min  = cfg_data;
                REG_ONE_MAX:  win_next.one_max  = cfg_data;
                REG_MARK_MIN: win_next.mark_min = cfg_data;
                REG_MARK_MAX: win_next.mark_max = cfg_data;
                default:      win_next = win_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.sync_min <= RST_SYNC_MIN;
            win_reg.sync_max <= RST_SYNC_MAX;
            win_reg.zero_min <= RST_ZERO_MIN;
            win_reg.zero_max <= RST_ZERO_MAX;
            win_reg.one_min  <= RST_ONE_MIN;
            win_reg.one_max  <= RST_ONE_MAX;
            win_reg.mark_min <= RST_MARK_MIN;
            win_reg.mark_max <= RST_MARK_MAX;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    assign windows = win_reg;

endmodule

// ----- rtl/pwsfd_core.sv -----
`timescale 1ns / 1ps

module pwsfd_core
    import pwsfd_pkg::*;
#(
    parameter int FRAME_BITS = DEF_FRAME_BITS,
    parameter int WIDTH_BITS = DEF_WIDTH_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [WIDTH_BITS-1:0] pulse_width,
    input  logic                  pulse_high,
    input  windows_t              windows,
    output result_t               result
);

    localparam int COMP_W = (WIDTH_BITS > REG_W) ? WIDTH_BITS : REG_W;
    localparam int CNT_W  = $clog2(FRAME_BITS + 1);
    localparam logic [COMP_W-1:0] WMASK = COMP_W'({WIDTH_BITS{1'b1}});
    localparam logic [CNT_W-1:0]  FRAME_LEN = CNT_W'(FRAME_BITS);

    logic                  synced_reg;
    logic                  synced_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W-1:0]      count_inc;
    logic [FRAME_BITS-1:0] frame_reg;
    logic [FRAME_BITS-1:0] frame_next;
    logic [COMP_W-1:0]     width_ext;
    logic                  in_sync;
    logic                  in_zero;
    logic                  in_one;
    logic                  in_mark;
    logic                  done;

    // Exclusive window test; the bounds are cut to the pulse width range.
    function automatic logic in_window(input logic [COMP_W-1:0] w,
                                       input logic [REG_W-1:0]  lo,
                                       input logic [REG_W-1:0]  hi);
        logic [COMP_W-1:0] lo_m;
        logic [COMP_W-1:0] hi_m;
        lo_m = COMP_W'(lo) & WMASK;
        hi_m = COMP_W'(hi) & WMASK;
        return (w > lo_m) && (w < hi_m);
    endfunction

    assign width_ext = COMP_W'(pulse_width);
    assign in_sync   = in_window(width_ext, windows.sync_min, windows.sync_max);
    assign in_zero   = in_window(width_ext, windows.zero_min, windows.zero_max);
    assign in_one    = in_window(width_ext, windows.one_min, windows.one_max);
    assign in_mark   = in_window(width_ext, windows.mark_min, windows.mark_max);
    assign count_inc = count_reg + 1'b1;

    // Sync tracking and bit collection. Bits shift in at the bottom so the
    // first bit of a frame ends up as the most significant one.
    always_comb
    begin
        synced_next = synced_reg;
        count_next  = count_reg;
        frame_next  = frame_reg;
        done        = 1'b0;
        if (step)
        begin
            if (pulse_high)
            begin
                if (!in_mark)
                begin
                    synced_next = 1'b0;
                end
            end
            else if (!synced_reg)
            begin
                if (in_sync)
                begin
                    synced_next = 1'b1;
                    count_next  = '0;
                    frame_next  = '0;
                end
            end
            else
            begin
                if (in_zero || in_one)
                begin
                    count_next = count_inc;
                    frame_next = {frame_reg[FRAME_BITS-2:0], !in_zero};
                    if (count_inc == FRAME_LEN)
                    begin
                        done        = 1'b1;
                        synced_next = 1'b0;
                    end
                end
                else
                begin
                    synced_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            synced_reg <= 1'b0;
            count_reg  <= '0;
            frame_reg  <= '0;
        end
        else
        begin
            synced_reg <= synced_next;
            count_reg  <= count_next;
            frame_reg  <= frame_next;
        end
    end

    // Field extraction from the completed frame; all zero otherwise.
    always_comb
    begin
        result = '0;
        if (done)
        begin
            result.frame_done   = 1'b1;
            result.sensor_id    = frame_next[FRAME_BITS-1-POS_SENSOR_ID -: SENSOR_ID_W];
            result.rolling_id   = frame_next[FRAME_BITS-1-POS_ROLLING_ID -: ROLLING_ID_W];
            result.battery_flag = frame_next[FRAME_BITS-1-POS_BATTERY];
            result.button_flag  = frame_next[FRAME_BITS-1-POS_BUTTON];
            result.channel      = CHANNEL_W'(frame_next[FRAME_BITS-1-POS_CHANNEL -: CH_BITS_W])
                                  + CHANNEL_W'(1);
            result.temperature  = frame_next[FRAME_BITS-1-POS_TEMP -: TEMP_W];
        end
    end

endmodule

// ----- rtl/pulse_width_sensor_frame_decoder.sv -----
`timescale 1ns / 1ps
// A pulse is taken into the input register, then decoded into the result register,
// from which its result transfer is made; a stalled result stream holds the input stage.
// Throughput: one pulse per cycle while the result stream is not stalled; every pulse
// gives exactly one result transfer. The sync state and bit store update from the input
// register as it advances. Reset (rst_n low, asynchronous) empties both stages, returns
// to idle and restores the default pulse windows.

module pulse_width_sensor_frame_decoder
    import pwsfd_pkg::*;
#(
    parameter int FRAME_BITS = DEF_FRAME_BITS,
    parameter int WIDTH_BITS = DEF_WIDTH_BITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Pulse stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((WIDTH_BITS+7)/8)*8-1:0]     s_tdata,   // pulse_width
    input  logic                                s_tuser,   // pulse_high
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // sensor_id, rolling_id, battery_flag, button_flag, channel, temperature
    output logic [OUT_DATA_W-1:0]               m_tdata,
    output logic                                m_tuser,   // frame_done
    // Configuration writes
    input  logic                                cfg_we,
    input  logic [CFG_IDX_W-1:0]                cfg_index,
    input  logic [REG_W-1:0]                    cfg_data
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [WIDTH_BITS-1:0] in_width_reg;
    logic                  in_high_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    result_t               out_result_reg;
    result_t               result;
    windows_t              windows;
    logic                  advance;
    logic                  in_xfer;

    pwsfd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .windows   (windows)
    );

    pwsfd_core #(
        .FRAME_BITS (FRAME_BITS),
        .WIDTH_BITS (WIDTH_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .pulse_width (in_width_reg),
        .pulse_high  (in_high_reg),
        .windows     (windows),
        .result      (result)
    );

    // Handshake: the input stage moves on whenever the result register is
    // free or being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next  = in_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_width_reg <= s_tdata[WIDTH_BITS-1:0];
            in_high_reg  <= s_tuser;
        end
        if (advance)
        begin
            out_result_reg <= result;
        end
    end

    // Result transfer packing, first field in the lowest bits.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.frame_done;
    assign m_tdata  = {{OUT_PAD_W{1'b0}},
                       out_result_reg.temperature,
                       out_result_reg.channel,
                       out_result_reg.button_flag,
                       out_result_reg.battery_flag,
                       out_result_reg.rolling_id,
                       out_result_reg.sensor_id};

endmodule

// ----- rtl/pwsfd_checker.sv -----
`timescale 1ns / 1ps

module pwsfd_checker
    import pwsfd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser
);

    localparam int CH_LO = SENSOR_ID_W + ROLLING_ID_W + 2;

    // A stalled result transfer keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed while stalled");

    // A pulse that completes no frame reports all fields as zero.
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("non-frame result carries field data");

    // A completed frame always reports a channel from one to four.
    a_channel: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[CH_LO +: CHANNEL_W] != '0
                              && m_tdata[CH_LO + CHANNEL_W - 1] == 1'b0
                              || m_tdata[CH_LO +: CHANNEL_W] == CHANNEL_W'(4))
        else $error("frame result has a channel outside one to four");

    // Fill bits above the packed fields stay zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_DATA_W-1:OUT_FIELDS_W] == '0)
        else $error("result fill bits are not zero");

endmodule

bind pulse_width_sensor_frame_decoder pwsfd_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- test/pulse_width_sensor_frame_decoder_tb.sv -----
`timescale 1ns / 1ps

module pulse_width_sensor_frame_decoder_tb;
    import pwsfd_pkg::*;

    localparam int PERIOD      = 12;
    localparam int FRAME_LEN   = DEF_FRAME_BITS;
    localparam int PW_W        = ((DEF_WIDTH_BITS + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 130;
    localparam int NUM_PHASES  = 6;

    typedef struct {
        logic [DEF_WIDTH_BITS-1:0] width;
        logic                      high;
    } pulse_t;

    // Block ports.
    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [PW_W-1:0]       s_tdata;    // pulse_width
    logic                  s_tuser;    // pulse_high
    logic                  m_tvalid;
    logic                  m_tready;
    // sensor_id, rolling_id, battery_flag, button_flag, channel, temperature
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;    // frame_done
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [REG_W-1:0]      cfg_data;

    // Pulses waiting to be sent and decoded results waiting to arrive.
    pulse_t  pulse_q[$];
    result_t decoded_q[$];

    // Decoder state mirrored from the block.
    logic [REG_W-1:0]     win [NUM_REGS];
    logic                 synced = 1'b0;
    int                   bit_count = 0;
    logic [FRAME_LEN-1:0] frame_bits = '0;

    // Bookkeeping.
    int pulses_sent   = 0;
    int pulses_taken  = 0;
    int results_taken = 0;
    int frames_seen   = 0;
    int mismatches    = 0;
    int cycle_count   = 0;
    int phase_items   = 0;
    int send_gap      = 0;
    int sink_gap      = 0;
    int sink_seen     = 0;
    bit send_burst    = 1'b0;
    bit sink_burst    = 1'b0;

    pulse_width_sensor_frame_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(PERIOD / 2) clk = ~clk;

    // Exclusive window test on a pair of registers, lower bound at lo.
    function automatic bit in_win(input logic [REG_W-1:0] w, input cfg_index_t lo);
        return (w > win[lo]) && (w < win[int'(lo) + 1]);
    endfunction

    function automatic bit win_open(input cfg_index_t lo);
        return int'(win[int'(lo) + 1]) > int'(win[lo]) + 1;
    endfunction

    // Random width strictly inside an open window.
    function automatic logic [REG_W-1:0] rand_in(input cfg_index_t lo);
        return REG_W'($urandom_range(int'(win[lo]) + 1, int'(win[int'(lo) + 1]) - 1));
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 55)
            return 0;
        else if (r < 85)
            return int'($urandom_range(1, 3));
        else if (r < 97)
            return int'($urandom_range(4, 12));
        else
            return int'($urandom_range(20, 60));
    endfunction

    // Apply one pulse to the mirrored decoder and queue the result it yields.
    task automatic decode_pulse(input logic [REG_W-1:0] w, input logic hi);
        result_t r;
        logic    done;
        r    = '0;
        done = 1'b0;
        if (hi)
        begin
            if (!in_win(w, REG_MARK_MIN))
                synced = 1'b0;
        end
        else if (!synced)
        begin
            if (in_win(w, REG_SYNC_MIN))
            begin
                frame_bits = '0;
                bit_count  = 0;
                synced     = 1'b1;
            end
        end
        else
        begin
            // The zero window wins where it overlaps the one window.
            if (in_win(w, REG_ZERO_MIN))
                bit_count++;
            else if (in_win(w, REG_ONE_MIN))
            begin
                if (bit_count < FRAME_LEN)
                    frame_bits[FRAME_LEN-1-bit_count] = 1'b1;
                bit_count++;
            end
            else
                synced = 1'b0;
            if (synced && bit_count >= FRAME_LEN)
            begin
                done   = 1'b1;
                synced = 1'b0;
            end
        end
        if (done)
        begin
            r.frame_done   = 1'b1;
            r.sensor_id    = frame_bits[35:32];
            r.rolling_id   = frame_bits[31:24];
            r.battery_flag = frame_bits[23];
            r.button_flag  = frame_bits[22];
            r.channel      = {1'b0, frame_bits[21:20]} + 3'd1;
            r.temperature  = frame_bits[19:8];
        end
        decoded_q.push_back(r);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic push_pulse(input logic [REG_W-1:0] w, input logic hi);
        pulse_t p;
        p.width = w;
        p.high  = hi;
        pulse_q.push_back(p);
        phase_items++;
    endtask

    // One pulse of noise: full range, extremes, or right at a window edge.
    task automatic noise_pulse();
        int               r;
        logic [REG_W-1:0] w;
        r = int'($urandom_range(0, 3));
        if (r == 0)
            w = REG_W'($urandom_range(0, 65535));
        else if (r == 1)
            w = ($urandom_range(0, 1) != 0) ? REG_W'(16'hFFFF - $urandom_range(0, 1))
                                             : REG_W'($urandom_range(0, 1));
        else
            w = REG_W'(win[$urandom_range(0, NUM_REGS - 1)] + $urandom_range(0, 2) - 1);
        push_pulse(w, 1'($urandom_range(0, 1)));
    endtask

    // A frame cut after the given number of bits, followed by noise if cut short.
    task automatic add_frame(input int nbits);
        bit marks;
        bit bitv;
        // A zero-width high pulse never fits the mark window, so it forces idle.
        push_pulse('0, 1'b1);
        push_pulse(rand_in(REG_SYNC_MIN), 1'b0);
        marks = win_open(REG_MARK_MIN) && ($urandom_range(0, 1) != 0);
        for (int b = 0; b < nbits; b++)
        begin
            if (marks)
                push_pulse(rand_in(REG_MARK_MIN), 1'b1);
            bitv = 1'($urandom_range(0, 1));
            if (!win_open(REG_ONE_MIN))
                bitv = 1'b0;
            if (!win_open(REG_ZERO_MIN))
                bitv = 1'b1;
            push_pulse(bitv ? rand_in(REG_ONE_MIN) : rand_in(REG_ZERO_MIN), 1'b0);
        end
        if (nbits < FRAME_LEN)
            noise_pulse();
    endtask

    // Block the stimulus until every pulse has been sent and its result returned.
    task automatic wait_drained();
        while (!(pulse_q.size() == 0 && pulses_taken == pulses_sent &&
                 decoded_q.size() == 0))
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_windows(input logic [REG_W-1:0] vals [NUM_REGS]);
        for (int k = 0; k < NUM_REGS; k++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= cfg_index_t'(k);
            cfg_data  <= vals[k];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Pick the window setting of one phase.
    task automatic pick_windows(input int phase, output logic [REG_W-1:0] vals [NUM_REGS]);
        int a;
        int b;
        case (phase)
            1: vals = '{16'd0, 16'd65535, 16'd0, 16'd300, 16'd200, 16'd600, 16'd0, 16'd65535};
            2: vals = '{16'd100, 16'd102, 16'd9, 16'd11, 16'd65533, 16'd65535, 16'd0, 16'd2};
            3: vals = '{16'd7500, 16'd10000, 16'd1000, 16'd2000, 16'd4000, 16'd3000,
                        16'd500, 16'd501};
            NUM_PHASES: vals = '{RST_SYNC_MIN, RST_SYNC_MAX, RST_ZERO_MIN, RST_ZERO_MAX,
                                 RST_ONE_MIN, RST_ONE_MAX, RST_MARK_MIN, RST_MARK_MAX};
            default:
            begin
                for (int k = 0; k < NUM_REGS; k += 2)
                begin
                    a = int'($urandom_range(0, 60000));
                    b = a + int'($urandom_range(2, 5000));
                    // Now and then an inverted window.
                    if ($urandom_range(0, 5) == 0)
                    begin
                        vals[k]     = REG_W'(b);
                        vals[k + 1] = REG_W'(a);
                    end
                    else
                    begin
                        vals[k]     = REG_W'(a);
                        vals[k + 1] = REG_W'(b);
                    end
                end
            end
        endcase
    endtask

    // Random stimulus: mostly whole frames, some cut short, some noise.
    task automatic random_phase();
        int r;
        bit framable;
        phase_items = 0;
        framable = win_open(REG_SYNC_MIN) &&
                   (win_open(REG_ZERO_MIN) || win_open(REG_ONE_MIN));
        while (phase_items < PHASE_ITEMS)
        begin
            r = int'($urandom_range(0, 99));
            if (framable && r < 60)
                add_frame(FRAME_LEN);
            else if (framable && r < 80)
                add_frame(int'($urandom_range(0, FRAME_LEN - 1)));
            else
                repeat ($urandom_range(1, 6)) noise_pulse();
        end
    endtask

    // Pulse sender: presents the next queued pulse once the previous transfer is done.
    always @(negedge clk)
    begin : pulse_driver
        pulse_t p;
        logic   nv;
        if (rst_n)
        begin
            if ($urandom_range(0, 63) == 0)
                send_burst = !send_burst;
            nv = s_tvalid;
            if (s_tvalid && pulses_taken == pulses_sent)
                nv = 1'b0;
            if (!nv)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pulse_q.size() > 0)
                begin
                    p = pulse_q.pop_front();
                    s_tdata  <= p.width;
                    s_tuser  <= p.high;
                    pulses_sent++;
                    nv = 1'b1;
                    send_gap = send_burst ? 0 : idle_gap();
                end
            end
            s_tvalid <= nv;
        end
    end

    // Result receiver: stalls for a random gap after each transfer.
    always @(negedge clk)
    begin : result_sink
        if (rst_n)
        begin
            if ($urandom_range(0, 63) == 0)
                sink_burst = !sink_burst;
            if (results_taken != sink_seen)
            begin
                sink_seen = results_taken;
                sink_gap  = sink_burst ? 0 : idle_gap();
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Monitor: tracks register writes, decodes accepted pulses, checks results.
    always @(posedge clk)
    begin : monitor
        result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        if (rst_n)
        begin
            if (cfg_we)
                win[cfg_index] = cfg_data;
            if (m_tvalid && m_tready)
            begin
                results_taken++;
                if (decoded_q.size() == 0)
                begin
                    $error("Result transfer arrived with no decoded pulse pending");
                    mismatches++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("frame_done", int'(want.frame_done), int'(m_tuser));
                    check_field("sensor_id", int'(want.sensor_id), int'(m_tdata[3:0]));
                    check_field("rolling_id", int'(want.rolling_id), int'(m_tdata[11:4]));
                    check_field("battery_flag", int'(want.battery_flag), int'(m_tdata[12]));
                    check_field("button_flag", int'(want.button_flag), int'(m_tdata[13]));
                    check_field("channel", int'(want.channel), int'(m_tdata[16:14]));
                    check_field("temperature", int'(want.temperature),
                                int'($signed(m_tdata[28:17])));
                    if (m_tuser)
                        frames_seen++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                pulses_taken++;
                decode_pulse(s_tdata[DEF_WIDTH_BITS-1:0], s_tuser);
            end
        end
    end

    // Reset, directed pulses, then one random phase per window setting.
    initial
    begin : stimulus
        logic [REG_W-1:0] vals [NUM_REGS];
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_SYNC_MIN;
        cfg_data  = '0;
        win = '{RST_SYNC_MIN, RST_SYNC_MAX, RST_ZERO_MIN, RST_ZERO_MAX,
                RST_ONE_MIN, RST_ONE_MAX, RST_MARK_MIN, RST_MARK_MAX};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Width extremes, high pulses while idle, window edges and aborts.
        push_pulse(16'd0, 1'b0);
        push_pulse(16'd65535, 1'b0);
        push_pulse(16'd0, 1'b1);
        push_pulse(16'd65535, 1'b1);
        push_pulse(16'd7500, 1'b0);
        push_pulse(16'd10000, 1'b0);
        push_pulse(16'd7501, 1'b0);
        push_pulse(16'd330, 1'b1);
        push_pulse(16'd1600, 1'b0);
        push_pulse(16'd9999, 1'b0);
        push_pulse(16'd529, 1'b1);
        push_pulse(16'd1501, 1'b0);
        push_pulse(16'd3501, 1'b0);
        push_pulse(16'd2500, 1'b0);
        push_pulse(16'd7600, 1'b0);
        push_pulse(16'd4499, 1'b0);
        push_pulse(16'd65535, 1'b1);
        push_pulse(16'd8000, 1'b0);
        push_pulse(16'd3000, 1'b0);
        push_pulse(16'd2499, 1'b0);
        wait_drained();

        for (int phase = 1; phase <= NUM_PHASES; phase++)
        begin
            pick_windows(phase, vals);
            write_windows(vals);
            random_phase();
            wait_drained();
        end
        repeat (8) @(negedge clk);

        $display("Run covered %0d pulses and %0d result transfers, %0d complete frames,",
                 pulses_taken, results_taken, frames_seen);
        $display("over %0d window settings including wide, narrow and inverted windows.",
                 NUM_PHASES + 1);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
